/* sv/skf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Shared types, register indexes, item kinds and reset values.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int DATA_W = 32;
    localparam int GAIN_OUT_W = 17;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_UNCERTAINTY = 2'd3;

    // Input item kinds.
    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Register reset values.
    localparam logic [DATA_W-1:0] RST_PROCESS_NOISE       = 32'd65536;
    localparam logic [DATA_W-1:0] RST_MEASUREMENT_NOISE   = 32'd655360;
    localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE    = 32'd33980416;
    localparam logic [DATA_W-1:0] RST_INITIAL_UNCERTAINTY = 32'd655360000;
    // Initial uncertainty plus process noise; the reset values do not overflow.
    localparam logic [DATA_W-1:0] RST_PREDICTED_VARIANCE  = 32'd655425536;

    // Filter state handed between the control level and the arithmetic engine.
    typedef struct packed {
        logic [DATA_W-1:0] est;
        logic [DATA_W-1:0] ph;
    } t_skf_state;

endpackage

/* sv/skf_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman filter arithmetic engine
// One shared adder/subtractor under a small sequencer computes the gain by
// restoring division and both products by shift-and-add.
// ----------------------------------------------------------------------------
module skf_engine #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  skf_pkg::t_skf_state           i_state,
    input  logic signed [skf_pkg::DATA_W-1:0] i_measurement,
    input  logic [skf_pkg::DATA_W-1:0]    i_process_noise,
    input  logic [skf_pkg::DATA_W-1:0]    i_measurement_noise,
    output logic                          o_done,
    output skf_pkg::t_skf_state           o_state,
    output logic [FRAC_BITS:0]            o_gain
);
    import skf_pkg::*;

    localparam int GW = FRAC_BITS + 1;
    localparam int AW = GW + 34;
    localparam int CW = $clog2(GW);
    localparam logic [GW-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEN  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_DIFF = 3'd3;
    localparam logic [2:0] ST_MUL1 = 3'd4;
    localparam logic [2:0] ST_EST  = 3'd5;
    localparam logic [2:0] ST_MUL2 = 3'd6;
    localparam logic [2:0] ST_PQ   = 3'd7;

    logic [2:0]        r_state;
    logic [CW-1:0]     r_cnt;
    logic [AW-1:0]     r_acc;
    logic [GW-1:0]     r_quo;
    logic [GW-1:0]     r_mb;
    logic [32:0]       r_den;
    logic [32:0]       r_diff;
    logic [DATA_W-1:0] r_z;
    logic [DATA_W-1:0] r_est_new;
    logic [DATA_W-1:0] r_ph_new;
    logic              r_done;

    logic [AW-1:0] add_a;
    logic [AW-1:0] add_b;
    logic          add_sub;
    logic [AW-1:0] add_y;
    logic [AW-32:0] est_hi;
    logic [DATA_W-1:0] est_clamped;
    logic          last_step;

    assign last_step = (r_cnt == CW'(GW - 1));

    // Operand selection for the shared adder.
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (r_state)
            ST_DEN: begin
                add_a = AW'(i_state.ph);
                add_b = AW'(i_measurement_noise);
            end
            ST_DIV: begin
                add_a   = (r_cnt == '0) ? r_acc : (r_acc << 1);
                add_b   = AW'(r_den);
                add_sub = 1'b1;
            end
            ST_DIFF: begin
                add_a   = {{(AW-32){r_z[31]}}, r_z};
                add_b   = {{(AW-32){i_state.est[31]}}, i_state.est};
                add_sub = 1'b1;
            end
            ST_MUL1: begin
                add_a = r_acc << 1;
                add_b = r_mb[GW-1] ? {{(AW-33){r_diff[32]}}, r_diff} : '0;
            end
            ST_EST: begin
                add_a = {{(AW-32){i_state.est[31]}}, i_state.est};
                add_b = $signed(r_acc) >>> FRAC_BITS;
            end
            ST_MUL2: begin
                add_a = r_acc << 1;
                add_b = r_mb[GW-1] ? AW'(i_state.ph) : '0;
            end
            ST_PQ: begin
                add_a = AW'(r_acc[FRAC_BITS +: DATA_W]);
                add_b = AW'(i_process_noise);
            end
            default: begin
                add_a = '0;
            end
        endcase
        add_y = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
    end

    // Clamp the updated estimate to the signed 32-bit range.
    always_comb begin
        est_hi = add_y[AW-1:31];
        if ((&est_hi) || !(|est_hi)) begin
            est_clamped = add_y[31:0];
        end else if (add_y[AW-1]) begin
            est_clamped = 32'h8000_0000;
        end else begin
            est_clamped = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_z     <= i_measurement;
                        r_state <= ST_DEN;
                    end
                end
                ST_DEN: begin
                    r_den   <= add_y[32:0];
                    r_acc   <= AW'(i_state.ph);
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_den == '0) begin
                        // Both variances zero: the gain is zero.
                        r_quo   <= '0;
                        r_state <= ST_DIFF;
                    end else begin
                        if (!add_y[AW-1]) begin
                            r_acc <= add_y;
                        end else begin
                            r_acc <= add_a;
                        end
                        r_quo <= {r_quo[GW-2:0], ~add_y[AW-1]};
                        r_cnt <= r_cnt + 1'b1;
                        if (last_step) begin
                            r_state <= ST_DIFF;
                        end
                    end
                end
                ST_DIFF: begin
                    r_diff  <= add_y[32:0];
                    r_acc   <= '0;
                    r_mb    <= r_quo;
                    r_cnt   <= '0;
                    r_state <= ST_MUL1;
                end
                ST_MUL1: begin
                    r_acc <= add_y;
                    r_mb  <= r_mb << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (last_step) begin
                        r_state <= ST_EST;
                    end
                end
                ST_EST: begin
                    r_est_new <= est_clamped;
                    r_acc     <= '0;
                    r_mb      <= GAIN_ONE - r_quo;
                    r_cnt     <= '0;
                    r_state   <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_acc <= add_y;
                    r_mb  <= r_mb << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (last_step) begin
                        r_state <= ST_PQ;
                    end
                end
                ST_PQ: begin
                    // The sum of p and q saturates at the 32-bit maximum.
                    r_ph_new <= add_y[32] ? '1 : add_y[31:0];
                    r_done   <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_state.est = r_est_new;
    assign o_state.ph  = r_ph_new;
    assign o_gain      = r_quo;

endmodule

/* sv/scalar_kalman_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// One-dimensional Kalman filter with constant dynamics for one sensor channel.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on a valid/stall channel. Each item carries a kind bit
// (measurement update or restart) and a signed fixed-point measurement. Every
// transfer in yields exactly one result transfer out, carrying the current
// estimate and the most recent gain.
// A measurement runs through one shared adder: a restoring division for the
// gain (FRAC_BITS+1 steps) and two shift-and-add products (FRAC_BITS+1 steps
// each); the division is skipped when the variance and the measurement noise
// are both zero. A restart bypasses the engine and loads the filter state
// directly. One item is processed at a time; o_in_stall stays high from the
// input transfer until the result is placed in the output register, so a new
// item is accepted only after the previous result has moved there.
// The output register holds a result while i_out_stall is high, and the next
// input item is already accepted while it waits there.
// Configuration is written through a plain write port, by the user only while
// the filter is idle; the block itself does not enforce this. Reset loads the
// register defaults, sets the estimate to the initial estimate, the predicted
// variance to initial uncertainty plus process noise, and clears the gain.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic signed [skf_pkg::DATA_W-1:0] i_measurement,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [skf_pkg::DATA_W-1:0] o_estimate_out,
    output logic [skf_pkg::GAIN_OUT_W-1:0]    o_gain_out,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]        i_cfg_data
);
    import skf_pkg::*;

    // Configuration registers.
    logic [DATA_W-1:0] r_process_noise;
    logic [DATA_W-1:0] r_measurement_noise;
    logic [DATA_W-1:0] r_initial_estimate;
    logic [DATA_W-1:0] r_initial_uncertainty;

    // Filter state: estimate, predicted variance and the last gain.
    t_skf_state        r_state;
    logic [FRAC_BITS:0] r_gain;

    // Handshake control.
    logic r_busy;
    logic r_pend;
    logic r_out_valid;
    logic signed [DATA_W-1:0] r_out_est;
    logic [GAIN_OUT_W-1:0]    r_out_gain;

    logic in_xfer;
    logic out_free;
    logic [DATA_W:0] restart_sum;
    logic [DATA_W-1:0] restart_ph;

    t_skf_state         eng_state;
    logic               eng_done;
    logic [FRAC_BITS:0] eng_gain;

    assign in_xfer  = i_in_valid && !r_busy;
    assign out_free = !r_out_valid || !i_out_stall;

    // A restart reloads the variance as initial uncertainty plus q, saturated.
    assign restart_sum = {1'b0, r_initial_uncertainty} + {1'b0, r_process_noise};
    assign restart_ph  = restart_sum[DATA_W] ? '1 : restart_sum[DATA_W-1:0];

    skf_engine #(
        .FRAC_BITS(FRAC_BITS)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (in_xfer && (i_kind == KIND_MEASURE)),
        .i_state            (r_state),
        .i_measurement      (i_measurement),
        .i_process_noise    (r_process_noise),
        .i_measurement_noise(r_measurement_noise),
        .o_done             (eng_done),
        .o_state            (eng_state),
        .o_gain             (eng_gain)
    );

    // Configuration writes. An index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_noise       <= RST_PROCESS_NOISE;
            r_measurement_noise   <= RST_MEASUREMENT_NOISE;
            r_initial_estimate    <= RST_INITIAL_ESTIMATE;
            r_initial_uncertainty <= RST_INITIAL_UNCERTAINTY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROCESS_NOISE:       r_process_noise       <= i_cfg_data;
                REG_MEASUREMENT_NOISE:   r_measurement_noise   <= i_cfg_data;
                REG_INITIAL_ESTIMATE:    r_initial_estimate    <= i_cfg_data;
                REG_INITIAL_UNCERTAINTY: r_initial_uncertainty <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Filter state and the result hand-off. The state only changes on a
    // restart transfer or when the engine finishes an update; the result is
    // then copied into the output register as soon as that register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.est <= RST_INITIAL_ESTIMATE;
            r_state.ph  <= RST_PREDICTED_VARIANCE;
            r_gain      <= '0;
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_busy <= 1'b1;
                if (i_kind == KIND_RESTART) begin
                    // The last gain is kept across a restart.
                    r_state.est <= r_initial_estimate;
                    r_state.ph  <= restart_ph;
                    r_pend      <= 1'b1;
                end
            end
            if (eng_done) begin
                r_state <= eng_state;
                r_gain  <= eng_gain;
                r_pend  <= 1'b1;
            end
            if (r_pend && out_free) begin
                r_out_valid <= 1'b1;
                r_out_est   <= r_state.est;
                r_out_gain  <= GAIN_OUT_W'(r_gain);
                r_pend      <= 1'b0;
                r_busy      <= 1'b0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall     = r_busy;
    assign o_out_valid    = r_out_valid;
    assign o_estimate_out = r_out_est;
    assign o_gain_out     = r_out_gain;

endmodule
